FILE: rtl/psrt_pkg.sv
`timescale 1ns / 1ps
// Package for the perfect square root test block: controller/datapath structs,
// quadratic-residue screen moduli and tables. No dependencies.
package psrt_pkg;

    localparam int NUM_MODS = 6;
    localparam int RES_W    = 7;
    localparam int TAB_W    = 65;

    typedef struct packed {
        logic load;
        logic strip;
        logic root;
        logic finish;
    } psrt_cmd_t;

    typedef struct packed {
        logic zero;
        logic odd;
        logic tz_odd;
        logic last;
    } psrt_sts_t;

    typedef logic [RES_W-1:0] res_t;

    // Table bit s is set when s is a square modulo m; squares built by running sums.
    function automatic logic [TAB_W-1:0] qr_table(input int m);
        logic [TAB_W-1:0] t;
        int s;
        t = '0;
        s = 0;
        for (int k = 0; k < TAB_W; k++)
        begin
            if (k < m)
            begin
                t[s] = 1'b1;
                s = s + 2 * k + 1;
                if (s >= m) s = s - m;
                if (s >= m) s = s - m;
                if (s >= m) s = s - m;
            end
        end
        return t;
    endfunction

    localparam res_t MODS [NUM_MODS] = '{7'd64, 7'd63, 7'd65, 7'd11, 7'd17, 7'd19};

    localparam logic [TAB_W-1:0] QR_TAB [NUM_MODS] = '{
        qr_table(64), qr_table(63), qr_table(65),
        qr_table(11), qr_table(17), qr_table(19)
    };

    // (4r + d) mod k for r < k: at most two conditional subtracts.
    function automatic res_t res_step(input res_t r, input logic [1:0] d, input res_t k);
        logic [8:0] v;
        logic [8:0] k2;
        v  = {r, d};
        k2 = {1'b0, k, 1'b0};
        if (v >= k2) v = v - k2;
        if (v >= {2'b00, k}) v = v - {2'b00, k};
        return v[RES_W-1:0];
    endfunction

endpackage

FILE: rtl/psrt_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM for the perfect square root test block.
// Depends on psrt_pkg; drives psrt_dp through command/status structs.
module psrt_ctrl
    import psrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    input  psrt_sts_t sts,
    output psrt_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_STRIP = 4'b0010,
        ST_ROOT  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                priority if (sts.zero)
                    state_next = ST_DONE;
                else if (sts.odd)
                    state_next = sts.tz_odd ? ST_DONE : ST_ROOT;
                else
                    cmd.strip = 1'b1;
            end
            ST_ROOT:
            begin
                cmd.root = 1'b1;
                if (sts.last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/psrt_dp.sv
`timescale 1ns / 1ps
// Datapath: trailing-zero strip, radix-4 square root recurrence with residue screens
// run on the same digit stream, and result selection. Depends on psrt_pkg.
module psrt_dp
    import psrt_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic        clk,
    input  logic [63:0] value,
    input  psrt_cmd_t   cmd,
    output psrt_sts_t   sts,
    output logic        is_square,
    output logic [31:0] root
);

    localparam int VW    = (WIDTH < 64) ? WIDTH : 64;
    localparam int SW    = VW + (VW % 2);
    localparam int RW    = SW / 2;
    localparam int NITER = SW / 2;
    localparam int CW    = $clog2(NITER);
    localparam int TZW   = $clog2(VW);

    logic [SW-1:0]  op_reg,   op_next;
    logic [TZW-1:0] tz_reg,   tz_next;
    logic           zero_reg, zero_next;
    logic [RW:0]    rem_reg,  rem_next;
    logic [RW-1:0]  q_reg,    q_next;
    logic [CW-1:0]  iter_reg, iter_next;
    res_t           res_reg  [NUM_MODS];
    res_t           res_next [NUM_MODS];

    logic [3:0]     sh;
    logic [RW+1:0]  rr;
    logic [RW+1:0]  trial;
    logic           ge;
    logic [1:0]     dig;
    logic           screen_ok;

    // Trailing zeros of the low byte; a clear byte shifts by eight.
    always_comb
    begin
        sh = 4'd8;
        for (int i = 7; i >= 0; i--)
        begin
            if (op_reg[i])
                sh = 4'(i);
        end
    end

    assign dig   = op_reg[SW-1:SW-2];
    assign rr    = {rem_reg[RW-1:0], dig};
    assign trial = {q_reg, 2'b01};
    assign ge    = (rr >= trial);

    always_comb
    begin
        op_next   = op_reg;
        tz_next   = tz_reg;
        zero_next = zero_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        iter_next = iter_reg;
        res_next  = res_reg;
        if (cmd.load)
        begin
            op_next   = SW'(value[VW-1:0]);
            zero_next = (value[VW-1:0] == '0);
            tz_next   = '0;
            rem_next  = '0;
            q_next    = '0;
            iter_next = '0;
            for (int j = 0; j < NUM_MODS; j++)
                res_next[j] = '0;
        end
        else if (cmd.strip)
        begin
            op_next = op_reg >> sh;
            tz_next = tz_reg + TZW'(sh);
        end
        else if (cmd.root)
        begin
            op_next   = op_reg << 2;
            rem_next  = ge ? (RW+1)'(rr - trial) : (RW+1)'(rr);
            q_next    = {q_reg[RW-2:0], ge};
            iter_next = iter_reg + 1'b1;
            for (int j = 0; j < NUM_MODS; j++)
                res_next[j] = res_step(res_reg[j], dig, MODS[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        tz_reg   <= tz_next;
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        iter_reg <= iter_next;
        res_reg  <= res_next;
    end

    assign sts = '{zero:   zero_reg,
                   odd:    op_reg[0],
                   tz_odd: tz_reg[0],
                   last:   (iter_reg == CW'(NITER - 1))};

    always_comb
    begin
        screen_ok = 1'b1;
        for (int j = 0; j < NUM_MODS; j++)
            screen_ok = screen_ok & QR_TAB[j][res_reg[j]];
    end

    always_comb
    begin
        priority if (zero_reg)
        begin
            is_square = 1'b1;
            root      = '0;
        end
        else if (tz_reg[0] || !screen_ok)
        begin
            is_square = 1'b0;
            root      = '0;
        end
        else if (rem_reg == '0)
        begin
            is_square = 1'b1;
            root      = 32'(q_reg) << tz_reg[TZW-1:1];
        end
        else
        begin
            is_square = 1'b0;
            root      = 32'(q_reg);
        end
    end

endmodule

FILE: rtl/perfect_square_root_test_top.sv
`timescale 1ns / 1ps
// Top level of the perfect square root test block: stream ports and output register.
// Depends on psrt_pkg, psrt_ctrl and psrt_dp.
//
//  Channel  Dir  tdata (low bit first)                     Transaction
//  s_*      in   value[63:0]                               one integer to test
//  m_*      out  is_square[0], root[32:1], zero pad[39:33] one result per input
//
// One transaction runs a load step, trailing-zero strip steps of up to eight bits each,
// radix-4 root iterations and a hand-off to the output register.
// Zero and values with an odd count of trailing zeros skip the root recurrence.
// rst_n clears the controller and output valid. A stalled output holds in its register
// while the next input is accepted and worked on.
module perfect_square_root_test_top
    import psrt_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // is_square[0], root[32:1], zero[39:33]
);

    psrt_cmd_t   cmd;
    psrt_sts_t   sts;
    logic        dp_square;
    logic [31:0] dp_root;
    logic        out_free;

    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg,  out_data_next;

    assign out_free = !out_valid_reg || m_tready;

    psrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    psrt_dp #(
        .WIDTH (WIDTH)
    ) u_dp
    (
        .clk       (clk),
        .value     (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .is_square (dp_square),
        .root      (dp_root)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0, dp_root, dp_square};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
